FILE: sv/lfu_page_cache_directory_assert.svh
// Assertion macros for the LFU page cache directory.
// Used by the top level through `include; no other dependencies.
`ifndef LFU_PAGE_CACHE_DIRECTORY_ASSERT_SVH
`define LFU_PAGE_CACHE_DIRECTORY_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LPCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpcd: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define LPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpcd: next-cycle check failed");

`endif

FILE: sv/lpcd_pkg.sv
// Shared types and constants of the LFU page cache directory.
// No dependencies; used by all other files but the assertion header.
package lpcd_pkg;

    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_PAGE_BITS = 12;
    localparam int DEF_ADDR_BITS = 48;

    // fixed field widths of the item channels
    localparam int ADDR_FIELD_W = 48;
    localparam int SLOT_W       = 4;
    localparam int OFS_W        = 12;

    // use counters saturate at all ones
    localparam int COUNT_W = 32;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // per-slot verdict of the shared compare unit
    typedef struct packed {
        logic               empty;     // tag and count both zero
        logic               zero_cnt;  // count zero: lookup stops here
        logic               match;     // stored tag equals key
        logic               lower;     // first or new lowest count
        logic [COUNT_W-1:0] bumped;    // count + 1, saturating
    } eval_t;

endpackage

FILE: sv/lpcd_req_if.sv
// Request channel of the LFU page cache directory: action and address.
// Depends on lpcd_pkg.
interface lpcd_req_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [lpcd_pkg::ADDR_FIELD_W-1:0] address;

    modport source (output valid, output action, output address, input ready);
    modport sink   (input valid, input action, input address, output ready);
endinterface

FILE: sv/lpcd_rsp_if.sv
// Response channel of the LFU page cache directory.
// Depends on lpcd_pkg.
interface lpcd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [lpcd_pkg::SLOT_W-1:0] slot;
    logic [lpcd_pkg::OFS_W-1:0]  page_offset;
    logic                        evicted;

    modport source (output valid, output hit, output slot, output page_offset,
                    output evicted, input ready);
    modport sink   (input valid, input hit, input slot, input page_offset,
                    input evicted, output ready);
endinterface

FILE: sv/lpcd_store.sv
// Tag and use-count memory with one write and one registered read port.
// Per-slot valid bits make unwritten slots read as zero. Depends on lpcd_pkg.
module lpcd_store #(
    parameter int ENTRIES = lpcd_pkg::DEF_ENTRIES,
    parameter int TAG_W   = lpcd_pkg::DEF_ADDR_BITS - lpcd_pkg::DEF_PAGE_BITS,
    parameter int IDX_W   = $clog2(lpcd_pkg::DEF_ENTRIES)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [TAG_W-1:0]             rd_tag,
    output logic [lpcd_pkg::COUNT_W-1:0] rd_cnt,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [TAG_W-1:0]             wr_tag,
    input  logic [lpcd_pkg::COUNT_W-1:0] wr_cnt
);

    logic [TAG_W-1:0]             tag_mem [ENTRIES];
    logic [lpcd_pkg::COUNT_W-1:0] cnt_mem [ENTRIES];
    logic [ENTRIES-1:0]           valid_reg;

    logic [TAG_W-1:0]             tag_q_reg;
    logic [lpcd_pkg::COUNT_W-1:0] cnt_q_reg;
    logic                         vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr] <= wr_tag;
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (rd_en)
        begin
            tag_q_reg <= tag_mem[rd_addr];
            cnt_q_reg <= cnt_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written slot reads as its reset value
    assign rd_tag = vld_q_reg ? tag_q_reg : '0;
    assign rd_cnt = vld_q_reg ? cnt_q_reg : '0;

endmodule

FILE: sv/lpcd_slot_eval.sv
// Shared compare unit: judges one slot against the key and the running minimum.
// Depends on lpcd_pkg (eval_t, COUNT_W).
module lpcd_slot_eval #(
    parameter int TAG_W = lpcd_pkg::DEF_ADDR_BITS - lpcd_pkg::DEF_PAGE_BITS
) (
    input  logic [TAG_W-1:0]             key,
    input  logic [TAG_W-1:0]             slot_tag,
    input  logic [lpcd_pkg::COUNT_W-1:0] slot_cnt,
    input  logic [lpcd_pkg::COUNT_W-1:0] lowest,
    input  logic                         have_low,
    output lpcd_pkg::eval_t              verdict
);

    always_comb
    begin
        verdict.zero_cnt = (slot_cnt == '0);
        verdict.empty    = (slot_tag == '0) && verdict.zero_cnt;
        verdict.match    = (slot_tag == key);
        verdict.lower    = !have_low || (slot_cnt < lowest);
        verdict.bumped   = (&slot_cnt) ? slot_cnt : slot_cnt + lpcd_pkg::COUNT_W'(1);
    end

endmodule

FILE: sv/lfu_page_cache_directory.sv
// Top level of the LFU page cache directory: scan sequencer, result register.
// Depends on lpcd_pkg, lpcd_req_if, lpcd_rsp_if, lpcd_store, lpcd_slot_eval
// and lfu_page_cache_directory_assert.svh.
//
//  channel | dir | payload                              | accepted when
//  --------+-----+--------------------------------------+-------------------------
//  req     | in  | action, address[47:0]                | req.valid && req.ready
//  rsp     | out | hit, slot[3:0], page_offset, evicted | rsp.valid && rsp.ready
//
// One item scans the slots in order, one slot per cycle through a single
// compare unit fed by the registered read port of the slot memory.
// A hit or empty slot ends the scan early, before all 16 slots are read.
// req.ready is high only when no item is in flight; a held response stalls
// the next item's finish, never its scan. No clearing pass after reset.

`include "lfu_page_cache_directory_assert.svh"

module lfu_page_cache_directory #(
    parameter int ENTRIES   = lpcd_pkg::DEF_ENTRIES,
    parameter int PAGE_BITS = lpcd_pkg::DEF_PAGE_BITS,
    parameter int ADDR_BITS = lpcd_pkg::DEF_ADDR_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    lpcd_req_if.sink     req,
    lpcd_rsp_if.source   rsp
);

    // address bits above the input field width do not exist
    localparam int ADDR_W = (ADDR_BITS < lpcd_pkg::ADDR_FIELD_W) ?
                            ADDR_BITS : lpcd_pkg::ADDR_FIELD_W;
    localparam int TAG_W  = ADDR_W - PAGE_BITS;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = lpcd_pkg::COUNT_W;
    localparam int SW     = lpcd_pkg::SLOT_W;
    localparam int OW     = lpcd_pkg::OFS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic                act_reg, act_next;
    logic [TAG_W-1:0]    key_reg, key_next;
    logic [OW-1:0]       ofs_reg, ofs_next;

    // read issue counter counts to ENTRIES; eval index trails it by one
    logic [IDX_W:0]      rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]    ev_idx_reg, ev_idx_next;
    logic                ev_vld_reg, ev_vld_next;

    // running minimum for the eviction pick
    logic [CNT_W-1:0]    low_reg, low_next;
    logic                have_low_reg, have_low_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;

    logic                res_hit_reg, res_hit_next;
    logic                res_evict_reg, res_evict_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;

    logic                out_vld_reg, out_vld_next;
    logic                out_hit_reg, out_hit_next;
    logic                out_evict_reg, out_evict_next;
    logic [SW-1:0]       out_slot_reg, out_slot_next;
    logic [OW-1:0]       out_ofs_reg, out_ofs_next;

    logic                rd_en;
    logic [TAG_W-1:0]    rd_tag;
    logic [CNT_W-1:0]    rd_cnt;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [TAG_W-1:0]    wr_tag;
    logic [CNT_W-1:0]    wr_cnt;
    lpcd_pkg::eval_t     verdict;

    logic                req_fire;
    logic                rsp_fire;
    logic                last_slot;
    logic [IDX_W-1:0]    pick_now;
    logic [OW+PAGE_BITS-1:0] ofs_wide;
    logic [SW+IDX_W-1:0]     slot_wide;

    lpcd_store #(
        .ENTRIES (ENTRIES),
        .TAG_W   (TAG_W),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_tag  (rd_tag),
        .rd_cnt  (rd_cnt),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_tag  (wr_tag),
        .wr_cnt  (wr_cnt)
    );

    lpcd_slot_eval #(
        .TAG_W    (TAG_W)
    ) u_eval (
        .key      (key_reg),
        .slot_tag (rd_tag),
        .slot_cnt (rd_cnt),
        .lowest   (low_reg),
        .have_low (have_low_reg),
        .verdict  (verdict)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = out_vld_reg && rsp.ready;

    assign rsp.valid       = out_vld_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.page_offset = out_ofs_reg;
    assign rsp.evicted     = out_evict_reg;

    // offset and slot are fitted to the fixed field widths
    assign ofs_wide  = {{OW{1'b0}}, req.address[PAGE_BITS-1:0]};
    assign slot_wide = {{SW{1'b0}}, res_slot_reg};

    assign rd_en     = (state_reg == S_SCAN) && (rd_idx_reg < (IDX_W+1)'(ENTRIES));
    assign last_slot = (ev_idx_reg == IDX_W'(ENTRIES - 1));
    assign pick_now  = verdict.lower ? ev_idx_reg : pick_reg;

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        ofs_next       = ofs_reg;
        rd_idx_next    = rd_idx_reg;
        ev_idx_next    = ev_idx_reg;
        ev_vld_next    = ev_vld_reg;
        low_next       = low_reg;
        have_low_next  = have_low_reg;
        pick_next      = pick_reg;
        res_hit_next   = res_hit_reg;
        res_evict_next = res_evict_reg;
        res_slot_next  = res_slot_reg;
        out_vld_next   = out_vld_reg && !rsp_fire;
        out_hit_next   = out_hit_reg;
        out_evict_next = out_evict_reg;
        out_slot_next  = out_slot_reg;
        out_ofs_next   = out_ofs_reg;
        wr_en          = 1'b0;
        wr_addr        = ev_idx_reg;
        wr_tag         = key_reg;
        wr_cnt         = CNT_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    act_next       = req.action;
                    key_next       = req.address[ADDR_W-1:PAGE_BITS];
                    ofs_next       = ofs_wide[OW-1:0];
                    rd_idx_next    = '0;
                    ev_vld_next    = 1'b0;
                    have_low_next  = 1'b0;
                    pick_next      = '0;
                    res_hit_next   = 1'b0;
                    res_evict_next = 1'b0;
                    res_slot_next  = '0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + (IDX_W+1)'(1);
                end
                ev_vld_next = rd_en;
                ev_idx_next = rd_idx_reg[IDX_W-1:0];

                if (ev_vld_reg)
                begin
                    if (act_reg == lpcd_pkg::ACT_ADD)
                    begin
                        if (verdict.empty)
                        begin
                            // fill first empty slot
                            wr_en         = 1'b1;
                            res_slot_next = ev_idx_reg;
                            state_next    = S_FINISH;
                        end
                        else if (verdict.match)
                        begin
                            wr_en         = 1'b1;
                            wr_cnt        = verdict.bumped;
                            res_hit_next  = 1'b1;
                            res_slot_next = ev_idx_reg;
                            state_next    = S_FINISH;
                        end
                        else
                        begin
                            if (verdict.lower)
                            begin
                                low_next      = rd_cnt;
                                have_low_next = 1'b1;
                                pick_next     = ev_idx_reg;
                            end
                            if (last_slot)
                            begin
                                // full and no match: evict lowest count
                                wr_en          = 1'b1;
                                wr_addr        = pick_now;
                                res_evict_next = 1'b1;
                                res_slot_next  = pick_now;
                                state_next     = S_FINISH;
                            end
                        end
                    end
                    else
                    begin
                        if (verdict.zero_cnt)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (verdict.match)
                        begin
                            wr_en         = 1'b1;
                            wr_cnt        = verdict.bumped;
                            res_hit_next  = 1'b1;
                            res_slot_next = ev_idx_reg;
                            state_next    = S_FINISH;
                        end
                        else if (last_slot)
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end

            S_FINISH:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next   = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_evict_next = res_evict_reg;
                    out_slot_next  = slot_wide[SW-1:0];
                    out_ofs_next   = ofs_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= lpcd_pkg::ACT_ADD;
            key_reg       <= '0;
            ofs_reg       <= '0;
            rd_idx_reg    <= '0;
            ev_idx_reg    <= '0;
            ev_vld_reg    <= 1'b0;
            low_reg       <= '0;
            have_low_reg  <= 1'b0;
            pick_reg      <= '0;
            res_hit_reg   <= 1'b0;
            res_evict_reg <= 1'b0;
            res_slot_reg  <= '0;
            out_vld_reg   <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_evict_reg <= 1'b0;
            out_slot_reg  <= '0;
            out_ofs_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            key_reg       <= key_next;
            ofs_reg       <= ofs_next;
            rd_idx_reg    <= rd_idx_next;
            ev_idx_reg    <= ev_idx_next;
            ev_vld_reg    <= ev_vld_next;
            low_reg       <= low_next;
            have_low_reg  <= have_low_next;
            pick_reg      <= pick_next;
            res_hit_reg   <= res_hit_next;
            res_evict_reg <= res_evict_next;
            res_slot_reg  <= res_slot_next;
            out_vld_reg   <= out_vld_next;
            out_hit_reg   <= out_hit_next;
            out_evict_reg <= out_evict_next;
            out_slot_reg  <= out_slot_next;
            out_ofs_reg   <= out_ofs_next;
        end
    end

    // an accepted item always starts a scan
    `LPCD_ASSERT_NEXT(a_accept_scans, clk, rst_n, req_fire, state_reg == S_SCAN)
    // the directory is only written while a scan resolves
    `LPCD_ASSERT_IMPLY(a_write_in_scan, clk, rst_n, wr_en, state_reg == S_SCAN && ev_vld_reg)
    // a lookup never evicts, and an eviction is never a hit
    `LPCD_ASSERT_IMPLY(a_lookup_no_evict, clk, rst_n,
        state_reg == S_FINISH, !(res_evict_reg && (res_hit_reg || act_reg == lpcd_pkg::ACT_LOOKUP)))
    // a result waiting for its slot holds the finish state
    `LPCD_ASSERT_NEXT(a_finish_holds, clk, rst_n,
        state_reg == S_FINISH && out_vld_reg && !rsp.ready, state_reg == S_FINISH)

endmodule
